/* design/midpoint_line_rasterizer_top_assert.svh */
// ------------------------------------------------------------
// midpoint_line_rasterizer_top_assert: assertion macros
// Implication checks used at the end of the top level.
// ------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH

// consequent holds in the same cycle
`define MLR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("midpoint_line_rasterizer: assertion failed");

// consequent holds in the following cycle
`define MLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("midpoint_line_rasterizer: assertion failed");

`endif

/* design/mlr_pkg.sv */
// ------------------------------------------------------------
// mlr_pkg: midpoint line rasterizer package
// Shared constants, codes and types.
// ------------------------------------------------------------
package mlr_pkg;

   localparam int MLR_COORD_BITS     = 12;
   localparam int MLR_CFG_BITS       = 12;
   localparam int MLR_SHADE_BITS     = 8;
   localparam int MLR_CSR_DATA_BITS  = 32;
   localparam int MLR_CSR_ADDR_BITS  = 3;
   localparam int MLR_QUEUE_DEPTH    = 2;
   localparam int MLR_QUEUE_PTR_BITS = 1;

   localparam logic [MLR_CFG_BITS-1:0] MLR_IMAGE_SIZE_RESET = 12'd2048;

   typedef enum logic [0:0] {
      MLR_MODE_LOAD    = 1'b0,
      MLR_MODE_ADVANCE = 1'b1
   } mode_type;

   typedef enum logic [0:0] {
      MLR_REG_IMAGE_ROWS    = 1'b0,
      MLR_REG_IMAGE_COLUMNS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic pop;
      logic load;
   } back_status_type;

endpackage

/* design/mlr_front.sv */
// ------------------------------------------------------------
// mlr_front: item intake and line setup
// Picks major axis and direction, forms the decision terms.
// ------------------------------------------------------------
module mlr_front
   import mlr_pkg::*;
#(
   parameter int COORD_BITS = MLR_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic signed [COORD_BITS-1:0]  req_start_a,
   input  logic signed [COORD_BITS-1:0]  req_start_b,
   input  logic signed [COORD_BITS-1:0]  req_end_a,
   input  logic signed [COORD_BITS-1:0]  req_end_b,
   input  logic [MLR_SHADE_BITS-1:0]     req_shade,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output logic                          cmd_load,
   output logic                          cmd_major_is_b,
   output logic                          cmd_minor_down,
   output logic signed [COORD_BITS-1:0]  cmd_a,
   output logic signed [COORD_BITS-1:0]  cmd_b,
   output logic signed [COORD_BITS-1:0]  cmd_major_end,
   output logic signed [COORD_BITS+2:0]  cmd_decision,
   output logic signed [COORD_BITS+2:0]  cmd_step_straight,
   output logic signed [COORD_BITS+2:0]  cmd_step_diagonal,
   output logic [MLR_SHADE_BITS-1:0]     cmd_shade
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int DEC_BITS  = COORD_BITS + 3;

   logic signed [DIFF_BITS-1:0]  da;
   logic signed [DIFF_BITS-1:0]  db;
   logic signed [DIFF_BITS-1:0]  ada;
   logic signed [DIFF_BITS-1:0]  adb;
   logic signed [DIFF_BITS-1:0]  dmin;
   logic                         major_b;
   logic                         swap;
   logic                         take;

   logic                         s_valid_ff, s_valid_in;
   logic                         s_load_ff, s_load_in;
   logic                         s_major_b_ff, s_major_b_in;
   logic signed [COORD_BITS-1:0] s_a_ff, s_a_in;
   logic signed [COORD_BITS-1:0] s_b_ff, s_b_in;
   logic signed [COORD_BITS-1:0] s_end_ff, s_end_in;
   logic signed [DIFF_BITS-1:0]  s_maj_ff, s_maj_in;
   logic signed [DIFF_BITS-1:0]  s_mnr_ff, s_mnr_in;
   logic [MLR_SHADE_BITS-1:0]    s_shade_ff, s_shade_in;

   logic signed [DEC_BITS-1:0]   mnr_x;
   logic signed [DEC_BITS-1:0]   maj_x;
   logic signed [DEC_BITS-1:0]   twice_mnr;
   logic signed [DEC_BITS-1:0]   diag_half;

   assign req_ready = !s_valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      da      = DIFF_BITS'(req_end_a) - DIFF_BITS'(req_start_a);
      db      = DIFF_BITS'(req_end_b) - DIFF_BITS'(req_start_b);
      ada     = da[DIFF_BITS-1] ? -da : da;
      adb     = db[DIFF_BITS-1] ? -db : db;
      major_b = !(ada > adb);
      swap    = major_b ? db[DIFF_BITS-1] : da[DIFF_BITS-1];
      dmin    = major_b ? da : db;

      s_load_in    = (mode_type'(req_mode) == MLR_MODE_LOAD);
      s_major_b_in = major_b;
      s_a_in       = swap ? req_end_a : req_start_a;
      s_b_in       = swap ? req_end_b : req_start_b;
      if (major_b) begin
         s_end_in = swap ? req_start_b : req_end_b;
      end else begin
         s_end_in = swap ? req_start_a : req_end_a;
      end
      s_maj_in   = major_b ? adb : ada;
      s_mnr_in   = swap ? -dmin : dmin;
      s_shade_in = req_shade;

      if (take) begin
         s_valid_in = 1'b1;
      end else if (cmd_ready) begin
         s_valid_in = 1'b0;
      end else begin
         s_valid_in = s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
      if (take) begin
         s_load_ff    <= s_load_in;
         s_major_b_ff <= s_major_b_in;
         s_a_ff       <= s_a_in;
         s_b_ff       <= s_b_in;
         s_end_ff     <= s_end_in;
         s_maj_ff     <= s_maj_in;
         s_mnr_ff     <= s_mnr_in;
         s_shade_ff   <= s_shade_in;
      end
   end

   always_comb begin
      mnr_x     = DEC_BITS'(s_mnr_ff);
      maj_x     = DEC_BITS'(s_maj_ff);
      twice_mnr = mnr_x + mnr_x;
      diag_half = s_mnr_ff[DIFF_BITS-1] ? (mnr_x + maj_x) : (mnr_x - maj_x);
   end

   assign cmd_valid         = s_valid_ff;
   assign cmd_load          = s_load_ff;
   assign cmd_major_is_b    = s_major_b_ff;
   assign cmd_minor_down    = s_mnr_ff[DIFF_BITS-1];
   assign cmd_a             = s_a_ff;
   assign cmd_b             = s_b_ff;
   assign cmd_major_end     = s_end_ff;
   assign cmd_decision      = s_mnr_ff[DIFF_BITS-1] ? (twice_mnr + maj_x)
                                                    : (twice_mnr - maj_x);
   assign cmd_step_straight = twice_mnr;
   assign cmd_step_diagonal = diag_half + diag_half;
   assign cmd_shade         = s_shade_ff;

endmodule

/* design/mlr_queue.sv */
// ------------------------------------------------------------
// mlr_queue: command queue
// Short FIFO between line setup and pixel stepping.
// ------------------------------------------------------------
module mlr_queue
   import mlr_pkg::*;
#(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]              entry_ff [MLR_QUEUE_DEPTH];
   logic [MLR_QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MLR_QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MLR_QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                          push;
   logic                          pop;

   assign push_ready = (count_ff != (MLR_QUEUE_PTR_BITS+1)'(MLR_QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/mlr_back.sv */
// ------------------------------------------------------------
// mlr_back: pixel stepper
// Holds the line state, emits one pixel per load or busy advance, registers output.
// ------------------------------------------------------------
module mlr_back
   import mlr_pkg::*;
#(
   parameter int COORD_BITS = MLR_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  logic                          cmd_load,
   input  logic                          cmd_major_is_b,
   input  logic                          cmd_minor_down,
   input  logic signed [COORD_BITS-1:0]  cmd_a,
   input  logic signed [COORD_BITS-1:0]  cmd_b,
   input  logic signed [COORD_BITS-1:0]  cmd_major_end,
   input  logic signed [COORD_BITS+2:0]  cmd_decision,
   input  logic signed [COORD_BITS+2:0]  cmd_step_straight,
   input  logic signed [COORD_BITS+2:0]  cmd_step_diagonal,
   input  logic [MLR_SHADE_BITS-1:0]     cmd_shade,
   input  logic [MLR_CFG_BITS-1:0]       image_rows,
   input  logic [MLR_CFG_BITS-1:0]       image_columns,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_pixel_a,
   output logic signed [COORD_BITS-1:0]  rsp_pixel_b,
   output logic [MLR_SHADE_BITS-1:0]     rsp_pixel_shade,
   output logic                          rsp_inside_res,
   output logic                          rsp_last,
   output back_status_type               status
);

   localparam int DEC_BITS = COORD_BITS + 3;
   localparam int CMP_BITS = (COORD_BITS > MLR_CFG_BITS) ? COORD_BITS : MLR_CFG_BITS;

   logic signed [COORD_BITS-1:0] cur_a_ff, cur_a_in;
   logic signed [COORD_BITS-1:0] cur_b_ff, cur_b_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic signed [DEC_BITS-1:0]   step_straight_ff, step_straight_in;
   logic signed [DEC_BITS-1:0]   step_diagonal_ff, step_diagonal_in;
   logic                         major_is_b_ff, major_is_b_in;
   logic                         minor_down_ff, minor_down_in;
   logic [MLR_SHADE_BITS-1:0]    held_shade_ff, held_shade_in;
   logic                         busy_ff, busy_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] pix_a_ff;
   logic signed [COORD_BITS-1:0] pix_b_ff;
   logic [MLR_SHADE_BITS-1:0]    pix_shade_ff;
   logic                         inside_ff, inside_in;
   logic                         last_ff, last_in;

   logic                         pop;
   logic                         emit;
   logic                         diag;
   logic                         dec_pos;
   logic                         dec_nonpos;
   logic signed [COORD_BITS-1:0] minor_cur;
   logic signed [COORD_BITS-1:0] minor_next;
   logic signed [COORD_BITS-1:0] major_next;

   assign pop       = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = pop;
   assign emit      = pop && (cmd_load || busy_ff);

   always_comb begin
      dec_nonpos = decision_ff[DEC_BITS-1] || (decision_ff == '0);
      dec_pos    = !dec_nonpos;
      diag       = minor_down_ff ? dec_nonpos : dec_pos;
      minor_cur  = major_is_b_ff ? cur_a_ff : cur_b_ff;
      if (diag) begin
         minor_next = minor_down_ff ? minor_cur - 1'b1 : minor_cur + 1'b1;
      end else begin
         minor_next = minor_cur;
      end

      major_end_in     = major_end_ff;
      step_straight_in = step_straight_ff;
      step_diagonal_in = step_diagonal_ff;
      major_is_b_in    = major_is_b_ff;
      minor_down_in    = minor_down_ff;
      held_shade_in    = held_shade_ff;
      if (cmd_load) begin
         cur_a_in         = cmd_a;
         cur_b_in         = cmd_b;
         major_end_in     = cmd_major_end;
         decision_in      = cmd_decision;
         step_straight_in = cmd_step_straight;
         step_diagonal_in = cmd_step_diagonal;
         major_is_b_in    = cmd_major_is_b;
         minor_down_in    = cmd_minor_down;
         held_shade_in    = cmd_shade;
      end else begin
         decision_in = decision_ff + (diag ? step_diagonal_ff : step_straight_ff);
         if (major_is_b_ff) begin
            cur_a_in = minor_next;
            cur_b_in = cur_b_ff + 1'b1;
         end else begin
            cur_a_in = cur_a_ff + 1'b1;
            cur_b_in = minor_next;
         end
      end

      major_next = major_is_b_in ? cur_b_in : cur_a_in;
      last_in    = (major_next == major_end_in);
      busy_in    = !last_in;
      inside_in  = !cur_a_in[COORD_BITS-1] && !cur_b_in[COORD_BITS-1]
                   && (CMP_BITS'($unsigned(cur_a_in)) < CMP_BITS'(image_rows))
                   && (CMP_BITS'($unsigned(cur_b_in)) < CMP_BITS'(image_columns));

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            busy_ff <= busy_in;
         end
      end
      if (emit) begin
         cur_a_ff         <= cur_a_in;
         cur_b_ff         <= cur_b_in;
         major_end_ff     <= major_end_in;
         decision_ff      <= decision_in;
         step_straight_ff <= step_straight_in;
         step_diagonal_ff <= step_diagonal_in;
         major_is_b_ff    <= major_is_b_in;
         minor_down_ff    <= minor_down_in;
         held_shade_ff    <= held_shade_in;
         pix_a_ff         <= cur_a_in;
         pix_b_ff         <= cur_b_in;
         pix_shade_ff     <= held_shade_in;
         inside_ff        <= inside_in;
         last_ff          <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_a     = pix_a_ff;
   assign rsp_pixel_b     = pix_b_ff;
   assign rsp_pixel_shade = pix_shade_ff;
   assign rsp_inside_res  = inside_ff;
   assign rsp_last        = last_ff;

   assign status.busy = busy_ff;
   assign status.pop  = pop;
   assign status.load = cmd_load;

endmodule

/* design/midpoint_line_rasterizer_top.sv */
// ------------------------------------------------------------
// midpoint_line_rasterizer_top: midpoint line rasterizer
// Path: an accepted item is registered in line setup, then in the command queue, then at the stepper output.
// Throughput: 1 item per cycle while rsp_ready is high, set by the one add and compare of the pixel step.
// Reset: synchronous; block idle, queue empty, image size 2048 x 2048.
// ------------------------------------------------------------
`include "midpoint_line_rasterizer_top_assert.svh"

module midpoint_line_rasterizer_top
   import mlr_pkg::*;
#(
   parameter int COORD_BITS = MLR_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic signed [COORD_BITS-1:0]  req_start_a,
   input  logic signed [COORD_BITS-1:0]  req_start_b,
   input  logic signed [COORD_BITS-1:0]  req_end_a,
   input  logic signed [COORD_BITS-1:0]  req_end_b,
   input  logic [MLR_SHADE_BITS-1:0]     req_shade,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_pixel_a,
   output logic signed [COORD_BITS-1:0]  rsp_pixel_b,
   output logic [MLR_SHADE_BITS-1:0]     rsp_pixel_shade,
   output logic                          rsp_inside_res,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [MLR_CSR_ADDR_BITS-1:0]  paddr,
   input  logic [MLR_CSR_DATA_BITS-1:0]  pwdata,
   output logic [MLR_CSR_DATA_BITS-1:0]  prdata,
   output logic                          pready
);

   localparam int DEC_BITS = COORD_BITS + 3;
   localparam int CMD_BITS = 3 + 3 * COORD_BITS + 3 * DEC_BITS + MLR_SHADE_BITS;

   logic [MLR_CFG_BITS-1:0] image_rows_ff, image_rows_in;
   logic [MLR_CFG_BITS-1:0] image_columns_ff, image_columns_in;
   logic                    csr_write;
   csr_index_type           csr_index;

   logic                         f_valid, f_ready;
   logic                         f_load, f_major_is_b, f_minor_down;
   logic signed [COORD_BITS-1:0] f_a, f_b, f_major_end;
   logic signed [DEC_BITS-1:0]   f_decision, f_step_straight, f_step_diagonal;
   logic [MLR_SHADE_BITS-1:0]    f_shade;

   logic                         q_valid, q_ready;
   logic [CMD_BITS-1:0]          q_push_data, q_pop_data;
   logic                         b_load, b_major_is_b, b_minor_down;
   logic signed [COORD_BITS-1:0] b_a, b_b, b_major_end;
   logic signed [DEC_BITS-1:0]   b_decision, b_step_straight, b_step_diagonal;
   logic [MLR_SHADE_BITS-1:0]    b_shade;
   back_status_type              back_status;

   // register file
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      image_rows_in    = image_rows_ff;
      image_columns_in = image_columns_ff;
      if (csr_write) begin
         case (csr_index)
            MLR_REG_IMAGE_ROWS: begin
               image_rows_in = pwdata[MLR_CFG_BITS-1:0];
            end
            MLR_REG_IMAGE_COLUMNS: begin
               image_columns_in = pwdata[MLR_CFG_BITS-1:0];
            end
            default: begin
               image_rows_in = image_rows_ff;
            end
         endcase
      end
      case (csr_index)
         MLR_REG_IMAGE_ROWS: begin
            prdata = MLR_CSR_DATA_BITS'(image_rows_ff);
         end
         MLR_REG_IMAGE_COLUMNS: begin
            prdata = MLR_CSR_DATA_BITS'(image_columns_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff    <= MLR_IMAGE_SIZE_RESET;
         image_columns_ff <= MLR_IMAGE_SIZE_RESET;
      end else begin
         image_rows_ff    <= image_rows_in;
         image_columns_ff <= image_columns_in;
      end
   end

   mlr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_start_a       (req_start_a),
      .req_start_b       (req_start_b),
      .req_end_a         (req_end_a),
      .req_end_b         (req_end_b),
      .req_shade         (req_shade),
      .cmd_valid         (f_valid),
      .cmd_ready         (f_ready),
      .cmd_load          (f_load),
      .cmd_major_is_b    (f_major_is_b),
      .cmd_minor_down    (f_minor_down),
      .cmd_a             (f_a),
      .cmd_b             (f_b),
      .cmd_major_end     (f_major_end),
      .cmd_decision      (f_decision),
      .cmd_step_straight (f_step_straight),
      .cmd_step_diagonal (f_step_diagonal),
      .cmd_shade         (f_shade)
   );

   assign q_push_data = {f_load, f_major_is_b, f_minor_down, f_a, f_b, f_major_end,
                         f_decision, f_step_straight, f_step_diagonal, f_shade};

   mlr_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_pop_data)
   );

   assign {b_load, b_major_is_b, b_minor_down, b_a, b_b, b_major_end,
           b_decision, b_step_straight, b_step_diagonal, b_shade} = q_pop_data;

   mlr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_valid),
      .cmd_ready         (q_ready),
      .cmd_load          (b_load),
      .cmd_major_is_b    (b_major_is_b),
      .cmd_minor_down    (b_minor_down),
      .cmd_a             (b_a),
      .cmd_b             (b_b),
      .cmd_major_end     (b_major_end),
      .cmd_decision      (b_decision),
      .cmd_step_straight (b_step_straight),
      .cmd_step_diagonal (b_step_diagonal),
      .cmd_shade         (b_shade),
      .image_rows        (image_rows_ff),
      .image_columns     (image_columns_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_a       (rsp_pixel_a),
      .rsp_pixel_b       (rsp_pixel_b),
      .rsp_pixel_shade   (rsp_pixel_shade),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_last          (rsp_last),
      .status            (back_status)
   );

   // line state agrees with the pixel on show
   `MLR_ASSERT_NOW(a_busy_tracks_last, clock, reset, rsp_valid, back_status.busy == !rsp_last)
   `MLR_ASSERT_NEXT(a_load_emits, clock, reset, back_status.pop && back_status.load, rsp_valid)
   `MLR_ASSERT_NEXT(a_idle_step_silent, clock, reset, back_status.pop && !back_status.load && !back_status.busy, !rsp_valid)

endmodule

/* dv/midpoint_line_rasterizer_top_tb.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------
// midpoint_line_rasterizer_top_tb: line rasterizer testbench
// Loads lines and steps them pixel by pixel through the valid/ready
// channels, predicting every pixel from an in-bench copy of the
// midpoint stepping and image bounds, and checks each result item in order.
// Register access, directed corner lines and random line sequences are run
// under varying image sizes and idle patterns on both channels.
// ------------------------------------------------------------
module midpoint_line_rasterizer_top_tb;
   import mlr_pkg::*;

   typedef logic signed [MLR_COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type                 a;
      coord_type                 b;
      logic [MLR_SHADE_BITS-1:0] shade;
      logic                      in_image;
      logic                      last;
   } pixel_type;

   localparam int HOLD_OFF_CYCLES = 6;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   mode_type                     req_mode = MLR_MODE_LOAD;
   coord_type                    req_start_a = '0;
   coord_type                    req_start_b = '0;
   coord_type                    req_end_a = '0;
   coord_type                    req_end_b = '0;
   logic [MLR_SHADE_BITS-1:0]    req_shade = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   coord_type                    rsp_pixel_a;
   coord_type                    rsp_pixel_b;
   logic [MLR_SHADE_BITS-1:0]    rsp_pixel_shade;
   logic                         rsp_inside_res;
   logic                         rsp_last;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [MLR_CSR_ADDR_BITS-1:0] paddr = '0;
   logic [MLR_CSR_DATA_BITS-1:0] pwdata = '0;
   logic [MLR_CSR_DATA_BITS-1:0] prdata;
   logic                         pready;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int error_count = 0;

   // predicted line state and image size
   int image_rows = 2048;
   int image_columns = 2048;
   int line_a = 0;
   int line_b = 0;
   int line_end = 0;
   int line_decision = 0;
   int line_straight_step = 0;
   int line_diag_step = 0;
   bit line_major_b = 1'b0;
   bit line_down = 1'b0;
   bit line_busy = 1'b0;
   logic [MLR_SHADE_BITS-1:0] line_shade = '0;

   pixel_type expected_pixels[$];

   midpoint_line_rasterizer_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_start_a     (req_start_a),
      .req_start_b     (req_start_b),
      .req_end_a       (req_end_a),
      .req_end_b       (req_end_b),
      .req_shade       (req_shade),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_a     (rsp_pixel_a),
      .rsp_pixel_b     (rsp_pixel_b),
      .rsp_pixel_shade (rsp_pixel_shade),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic void check_field(string name, int want, int seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         error_count++;
      end
   endfunction

   // one load or advance item; returns whether a pixel follows
   function automatic bit predict_pixel(input mode_type mode, input coord_type sa, sb, ea, eb,
                                        input logic [MLR_SHADE_BITS-1:0] shade,
                                        output pixel_type px);
      int a0, b0, a1, b1, t, da, db, maj, mnr, minor_step, major_pos;
      bit diag;
      a0 = sa;
      b0 = sb;
      a1 = ea;
      b1 = eb;
      px = '0;
      if (mode == MLR_MODE_LOAD) begin
         da = a1 - a0;
         db = b1 - b0;
         line_major_b = !((da < 0 ? -da : da) > (db < 0 ? -db : db));
         if (line_major_b ? (b1 < b0) : (a1 < a0)) begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
         end
         maj = line_major_b ? b1 - b0 : a1 - a0;
         mnr = line_major_b ? a1 - a0 : b1 - b0;
         line_down = mnr < 0;
         line_decision = line_down ? 2 * mnr + maj : 2 * mnr - maj;
         line_diag_step = line_down ? 2 * (mnr + maj) : 2 * (mnr - maj);
         line_straight_step = 2 * mnr;
         line_a = a0;
         line_b = b0;
         line_end = line_major_b ? b1 : a1;
         line_shade = shade;
      end else begin
         if (!line_busy) return 1'b0;
         diag = line_down ? (line_decision <= 0) : (line_decision > 0);
         minor_step = line_down ? -1 : 1;
         if (diag) begin
            line_decision += line_diag_step;
            if (line_major_b) line_a += minor_step;
            else line_b += minor_step;
         end else begin
            line_decision += line_straight_step;
         end
         if (line_major_b) line_b++;
         else line_a++;
      end
      major_pos = line_major_b ? line_b : line_a;
      px.a = line_a[MLR_COORD_BITS-1:0];
      px.b = line_b[MLR_COORD_BITS-1:0];
      px.shade = line_shade;
      px.in_image = line_a >= 0 && line_a < image_rows && line_b >= 0 && line_b < image_columns;
      px.last = major_pos == line_end;
      line_busy = !px.last;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel item at (%0d, %0d)", rsp_pixel_a, rsp_pixel_b);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_a", want.a, rsp_pixel_a);
            check_field("pixel_b", want.b, rsp_pixel_b);
            check_field("pixel_shade", want.shade, rsp_pixel_shade);
            check_field("inside_res", want.in_image, rsp_inside_res);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   function automatic int any_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   // endpoint within span of v, reflected back into range
   function automatic int near_coord(int v, int span);
      int w;
      w = v + int'($urandom_range(2 * span)) - span;
      if (w > 2047 || w < -2048) w = 2 * v - w;
      return w;
   endfunction

   function automatic int pick_image_size();
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return 2048;
         3: return int'($urandom_range(2048, 1));
         default: return int'($urandom_range(64, 1));
      endcase
   endfunction

   task automatic send_item(input mode_type mode, input int sa, sb, ea, eb, shade,
                            output bit produced);
      coord_type ca, cb, xa, xb;
      logic [MLR_SHADE_BITS-1:0] s;
      pixel_type px;
      ca = MLR_COORD_BITS'(sa);
      cb = MLR_COORD_BITS'(sb);
      xa = MLR_COORD_BITS'(ea);
      xb = MLR_COORD_BITS'(eb);
      s = MLR_SHADE_BITS'(shade);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_start_a <= ca;
      req_start_b <= cb;
      req_end_a   <= xa;
      req_end_b   <= xb;
      req_shade   <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = predict_pixel(mode, ca, cb, xa, xb, s, px);
      if (produced) expected_pixels.push_back(px);
   endtask

   task automatic send_tick(output bit produced);
      send_item(MLR_MODE_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(),
                int'($urandom_range(255)), produced);
   endtask

   // hold the sender until every pixel is out, then let the pipe empty
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MLR_CSR_ADDR_BITS'(int'(idx) * 4);
      pwdata  <= MLR_CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == MLR_REG_IMAGE_ROWS) image_rows = value & 'hFFF;
      else image_columns = value & 'hFFF;
      @(posedge clock);
   endtask

   task automatic csr_read(input csr_index_type idx, output logic [MLR_CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= MLR_CSR_ADDR_BITS'(int'(idx) * 4);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_csr_access();
      int sizes[3] = '{0, 1, 2048};
      logic [MLR_CSR_DATA_BITS-1:0] v;
      csr_read(MLR_REG_IMAGE_ROWS, v);
      check_field("image_rows", 2048, v);
      csr_read(MLR_REG_IMAGE_COLUMNS, v);
      check_field("image_columns", 2048, v);
      for (int i = 0; i < 3; i++) begin
         csr_write(MLR_REG_IMAGE_ROWS, sizes[i]);
         csr_write(MLR_REG_IMAGE_COLUMNS, sizes[2 - i]);
         csr_read(MLR_REG_IMAGE_ROWS, v);
         check_field("image_rows", sizes[i], v);
         csr_read(MLR_REG_IMAGE_COLUMNS, v);
         check_field("image_columns", sizes[2 - i], v);
      end
   endtask

   task automatic test_directed_lines();
      bit got;
      // zero columns: nothing is inside
      csr_write(MLR_REG_IMAGE_COLUMNS, 0);
      send_tick(got);
      send_item(MLR_MODE_LOAD, 0, 0, 0, 0, 0, got);
      settle_pipeline();
      csr_write(MLR_REG_IMAGE_COLUMNS, 2048);
      send_item(MLR_MODE_LOAD, -2048, 2047, -2048, 2047, 255, got);
      send_item(MLR_MODE_LOAD, 0, 0, 0, 3, 'h55, got);
      repeat (3) send_tick(got);
      send_item(MLR_MODE_LOAD, 3, 5, 0, 5, 'hAA, got);
      repeat (3) send_tick(got);
      // equal deltas: b is major, swapped, minor down
      send_item(MLR_MODE_LOAD, 0, 2, 2, 0, 1, got);
      repeat (2) send_tick(got);
      send_item(MLR_MODE_LOAD, -2048, -2048, 2047, 2047, 128, got);
      repeat (2) send_tick(got);
      // abandons the full-range line above
      send_item(MLR_MODE_LOAD, 2047, -2048, -2048, 2047, 127, got);
      repeat (2) send_tick(got);
      send_item(MLR_MODE_LOAD, 5, 5, 6, 7, 254, got);
      repeat (3) send_tick(got);
      settle_pipeline();
   endtask

   task automatic test_random_lines(input int sender_idle, receiver_idle, quota);
      int sent, next_cfg, r, span, sa, sb, cut, k;
      bit got, at_origin;
      send_idle_pct = sender_idle;
      rsp_idle_pct  = receiver_idle;
      sent = 0;
      next_cfg = 0;
      while (sent < quota) begin
         if (sent >= next_cfg) begin
            settle_pipeline();
            csr_write(MLR_REG_IMAGE_ROWS, pick_image_size());
            csr_write(MLR_REG_IMAGE_COLUMNS, pick_image_size());
            next_cfg = sent + 150;
         end
         if ($urandom_range(99) < 8) begin
            send_item(mode_type'($urandom_range(1)), any_coord(), any_coord(), any_coord(),
                      any_coord(), int'($urandom_range(255)), got);
            sent += got;
         end
         r = $urandom_range(99);
         span = r < 80 ? 8 : (r < 97 ? 40 : 300);
         at_origin = $urandom_range(1);
         sa = at_origin ? int'($urandom_range(96)) - 16 : any_coord();
         sb = at_origin ? int'($urandom_range(96)) - 16 : any_coord();
         send_item(MLR_MODE_LOAD, sa, sb, near_coord(sa, span), near_coord(sb, span),
                   int'($urandom_range(255)), got);
         sent += got;
         cut = ($urandom_range(9) == 0) ? int'($urandom_range(span, 1)) : -1;
         k = 0;
         while (line_busy && k != cut) begin
            send_tick(got);
            sent += got;
            k++;
         end
         if ($urandom_range(9) == 0) begin
            send_tick(got);
            sent += got;
         end
      end
      settle_pipeline();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_csr_access();
      test_directed_lines();
      test_random_lines(31, 47, 530);
      test_random_lines(47, 31, 530);
      test_random_lines(0, 0, 540);
      settle_pipeline();
      if (error_count == 0) begin
         $display("midpoint_line_rasterizer_top_tb: clean");
      end else begin
         $display("midpoint_line_rasterizer_top_tb: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("midpoint_line_rasterizer_top_tb: errors");
      $finish;
   end

endmodule
